// ===== hw/rtl/ole_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the ordered list engine.
package ole_pkg;

    localparam logic [2:0] MODE_APPEND = 3'd0;
    localparam logic [2:0] MODE_SORTED = 3'd1;
    localparam logic [2:0] MODE_INSERT = 3'd2;
    localparam logic [2:0] MODE_DELETE = 3'd3;
    localparam logic [2:0] MODE_SORT   = 3'd4;
    localparam logic [2:0] MODE_READ   = 3'd5;
    localparam logic [2:0] MODE_STATS  = 3'd6;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] value;
        logic [4:0]         position;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         entry_count;
        logic signed [31:0] read_value;
        logic signed [31:0] minimum;
        logic signed [31:0] maximum;
        logic signed [35:0] total;
        logic signed [31:0] average;
    } t_rsp;

endpackage

// ===== hw/rtl/ordered_list_engine.sv =====
`timescale 1ns / 1ps
// Ordered list engine: list kept in one sync RAM, walked by a sequencer.
//
//  channel  dir  valid         stall         payload
//  request  in   i_req_valid   o_req_stall   i_req (t_req)
//  result   out  o_rsp_valid   i_rsp_stall   o_rsp (t_rsp)
//
// One operation at a time; every RAM access has a read state and a use state.
// Reset empties the list at once (count to zero); RAM contents are not cleared.
// A finished result waits in FIN while an earlier result is still held by a stalled result channel.
module ordered_list_engine
    import ole_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_stall,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_stall,
    output t_rsp o_rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > 5) ? CW : 5) + 1;
    localparam int SW = 33 + $clog2(CAPACITY);
    localparam int KW = $clog2(SW + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_SHIFT_SET, S_SHIFT_RD, S_SHIFT_WR, S_PLACE,
        S_SRCH_RD, S_SRCH_EV, S_DEL_CHK, S_DEL_RD, S_DEL_WR,
        S_SORT_I, S_SORT_LD, S_SORT_RD, S_SORT_EV, S_SORT_WB,
        S_READ_RD, S_READ_EV, S_STAT_RD, S_STAT_EV,
        S_DIV_SET, S_DIV, S_DIV_END, S_FIN
    } t_state;

    logic [31:0] mem [CAPACITY];
    logic [31:0] r_rdata;

    t_state                r_state;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_i;
    logic [CW-1:0]         r_j;
    logic [CW-1:0]         r_slot;
    logic [31:0]           r_value;
    logic [31:0]           r_ei;
    logic                  r_le;
    logic [1:0]            r_status;
    logic signed [31:0]    r_rd;
    logic signed [31:0]    r_min;
    logic signed [31:0]    r_max;
    logic signed [SW-1:0]  r_sum;
    logic signed [31:0]    r_avg;
    logic                  r_neg;
    logic [SW-1:0]         r_dq;
    logic [CW-1:0]         r_rem;
    logic [KW-1:0]         r_k;
    logic                  r_rsp_valid;
    t_rsp                  r_rsp;

    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    logic [31:0]           mem_wd;
    logic [AW-1:0]         mem_ra;
    logic [CW-1:0]         ra_full;
    logic [CW-1:0]         wa_full;
    logic [CW-1:0]         i_m1;
    logic [CW-1:0]         i_p1;
    logic [CW-1:0]         j_p1;
    logic [PW-1:0]         pos_ext;
    logic [PW-1:0]         cnt_ext;
    logic                  pos_in_list;
    logic                  pos_in_ins;
    logic [CW-1:0]         pos_m1;
    logic                  sort_lt;
    logic                  srch_gt;
    logic [CW:0]           rem2;
    logic                  div_ge;
    logic [CW:0]           rem_sub;
    logic [SW-1:0]         sum_abs;
    logic [SW-1:0]         q_signed;
    logic signed [SW-1:0]  elem_ext;
    logic                  req_acc;

    assign i_m1    = r_i - 1'b1;
    assign i_p1    = r_i + 1'b1;
    assign j_p1    = r_j + 1'b1;
    assign pos_ext = PW'(i_req.position);
    assign cnt_ext = PW'(r_count);
    assign pos_in_list = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign pos_in_ins  = (pos_ext != '0) && (pos_ext <= cnt_ext + 1'b1);
    assign pos_m1  = CW'(pos_ext - 1'b1);
    assign sort_lt = $signed(r_rdata) < $signed(r_ei);
    assign srch_gt = $signed(r_rdata) > $signed(r_value);
    assign elem_ext = SW'($signed(r_rdata));
    assign rem2    = {r_rem, r_dq[SW-1]};
    assign div_ge  = rem2 >= {1'b0, r_count};
    assign rem_sub = div_ge ? (rem2 - {1'b0, r_count}) : rem2;
    assign sum_abs = r_sum[SW-1] ? (~r_sum + 1'b1) : r_sum;
    assign q_signed = r_neg ? (~r_dq + 1'b1) : r_dq;
    assign req_acc = i_req_valid && !o_req_stall;

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    always_comb begin
        mem_we  = 1'b0;
        wa_full = r_i;
        mem_wd  = r_rdata;
        ra_full = r_j;
        case (r_state)
            S_SHIFT_RD: ra_full = i_m1;
            S_SHIFT_WR: mem_we = 1'b1;
            S_PLACE: begin
                mem_we  = 1'b1;
                wa_full = r_slot;
                mem_wd  = r_value;
            end
            S_DEL_RD:   ra_full = i_p1;
            S_DEL_WR:   mem_we = 1'b1;
            S_SORT_I:   ra_full = r_i;
            S_SORT_EV: begin
                mem_we  = sort_lt;
                wa_full = r_j;
                mem_wd  = r_ei;
            end
            S_SORT_WB: begin
                mem_we = 1'b1;
                mem_wd = r_ei;
            end
            S_READ_RD:  ra_full = r_i;
            default: ;
        endcase
        mem_wa = wa_full[AW-1:0];
        mem_ra = ra_full[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            // FIN reloads the result register itself
            if (r_rsp_valid && !i_rsp_stall && r_state != S_FIN) begin
                r_rsp_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (req_acc) begin
                        r_value  <= i_req.value;
                        r_status <= ST_OK;
                        r_rd     <= '0;
                        r_min    <= '0;
                        r_max    <= '0;
                        r_sum    <= '0;
                        r_avg    <= '0;
                        r_i      <= r_count;
                        r_j      <= '0;
                        r_le     <= 1'b1;
                        r_state  <= S_FIN;
                        case (i_req.mode)
                            MODE_APPEND, MODE_SORTED, MODE_INSERT: begin
                                if (r_count >= CW'(CAPACITY)) begin
                                    r_status <= ST_FULL;
                                end else if (i_req.mode == MODE_APPEND) begin
                                    r_slot  <= r_count;
                                    r_state <= S_PLACE;
                                end else if (i_req.mode == MODE_SORTED) begin
                                    r_slot  <= '0;
                                    r_state <= (r_count == '0) ? S_PLACE : S_SRCH_RD;
                                end else if (!pos_in_ins) begin
                                    r_status <= ST_BADPOS;
                                end else begin
                                    r_slot  <= pos_m1;
                                    r_state <= S_SHIFT_SET;
                                end
                            end
                            MODE_DELETE, MODE_READ: begin
                                if (r_count == '0) begin
                                    r_status <= ST_EMPTY;
                                end else if (!pos_in_list) begin
                                    r_status <= ST_BADPOS;
                                end else begin
                                    r_i     <= pos_m1;
                                    r_state <= (i_req.mode == MODE_DELETE) ? S_DEL_CHK
                                                                           : S_READ_RD;
                                end
                            end
                            MODE_SORT: begin
                                r_i     <= '0;
                                r_state <= S_SORT_I;
                            end
                            MODE_STATS: begin
                                if (r_count == '0) begin
                                    r_status <= ST_EMPTY;
                                end else begin
                                    r_state <= S_STAT_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SHIFT_SET: r_state <= (r_i > r_slot) ? S_SHIFT_RD : S_PLACE;
                S_SHIFT_RD:  r_state <= S_SHIFT_WR;
                S_SHIFT_WR: begin
                    r_i     <= i_m1;
                    r_state <= (i_m1 > r_slot) ? S_SHIFT_RD : S_PLACE;
                end
                S_PLACE: begin
                    r_count <= r_count + 1'b1;
                    r_state <= S_FIN;
                end
                S_SRCH_RD: r_state <= S_SRCH_EV;
                S_SRCH_EV: begin
                    // slot j sits between an entry <= value and one > value
                    if (r_le && srch_gt) begin
                        r_slot  <= r_j;
                        r_state <= S_SHIFT_SET;
                    end else if (j_p1 == r_count) begin
                        r_slot  <= r_count;
                        r_state <= S_SHIFT_SET;
                    end else begin
                        r_le    <= !srch_gt;
                        r_j     <= j_p1;
                        r_state <= S_SRCH_RD;
                    end
                end
                S_DEL_CHK: begin
                    if (i_p1 < r_count) begin
                        r_state <= S_DEL_RD;
                    end else begin
                        r_count <= r_count - 1'b1;
                        r_state <= S_FIN;
                    end
                end
                S_DEL_RD: r_state <= S_DEL_WR;
                S_DEL_WR: begin
                    r_i     <= i_p1;
                    r_state <= S_DEL_CHK;
                end
                S_SORT_I: r_state <= (i_p1 < r_count) ? S_SORT_LD : S_FIN;
                S_SORT_LD: begin
                    r_ei    <= r_rdata;
                    r_j     <= i_p1;
                    r_state <= S_SORT_RD;
                end
                S_SORT_RD: r_state <= S_SORT_EV;
                S_SORT_EV: begin
                    if (sort_lt) begin
                        r_ei <= r_rdata;
                    end
                    r_j     <= j_p1;
                    r_state <= (j_p1 < r_count) ? S_SORT_RD : S_SORT_WB;
                end
                S_SORT_WB: begin
                    r_i     <= i_p1;
                    r_state <= S_SORT_I;
                end
                S_READ_RD: r_state <= S_READ_EV;
                S_READ_EV: begin
                    r_rd    <= $signed(r_rdata);
                    r_state <= S_FIN;
                end
                S_STAT_RD: r_state <= S_STAT_EV;
                S_STAT_EV: begin
                    if (r_j == '0 || $signed(r_rdata) < r_min) begin
                        r_min <= $signed(r_rdata);
                    end
                    if (r_j == '0 || $signed(r_rdata) > r_max) begin
                        r_max <= $signed(r_rdata);
                    end
                    r_sum   <= r_sum + elem_ext;
                    r_j     <= j_p1;
                    r_state <= (j_p1 == r_count) ? S_DIV_SET : S_STAT_RD;
                end
                S_DIV_SET: begin
                    r_neg   <= r_sum[SW-1];
                    r_dq    <= sum_abs;
                    r_rem   <= '0;
                    r_k     <= KW'(SW);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    r_rem   <= rem_sub[CW-1:0];
                    r_dq    <= {r_dq[SW-2:0], div_ge};
                    r_k     <= r_k - 1'b1;
                    r_state <= (r_k == KW'(1)) ? S_DIV_END : S_DIV;
                end
                S_DIV_END: begin
                    r_avg   <= $signed(q_signed[31:0]);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_rsp_valid || !i_rsp_stall) begin
                        r_rsp_valid         <= 1'b1;
                        r_rsp.status        <= r_status;
                        r_rsp.entry_count   <= 5'(r_count);
                        r_rsp.read_value    <= r_rd;
                        r_rsp.minimum       <= r_min;
                        r_rsp.maximum       <= r_max;
                        r_rsp.total         <= 36'(r_sum);
                        r_rsp.average       <= r_avg;
                        r_state             <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_rsp_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_rsp_valid) |-> $past(r_state == S_FIN))
        else $error("result raised outside finish state");

    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_rsp_valid && i_rsp_stall) |=> r_state == S_FIN)
        else $error("pending result overwritten");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_count))
        else $error("divider remainder out of range");

endmodule

// ===== bench/tb_ordered_list_engine.sv =====
`timescale 1ns / 1ps
// Testbench for the ordered list engine: directed table, then random traffic vs. a predictor.
module tb_ordered_list_engine;
    import ole_pkg::*;

    localparam int CAP       = 16;
    localparam int CYC_LIMIT = 1500000;
    localparam int N_RANDOM  = 1530;

    logic i_clk;
    logic i_rst_n;
    logic i_req_valid;
    logic o_req_stall;
    t_req i_req;
    logic o_rsp_valid;
    logic i_rsp_stall;
    t_rsp o_rsp;

    ordered_list_engine #(.CAPACITY(CAP)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // predictor copy of the list
    logic signed [31:0] shadow_list [CAP];
    int                 shadow_len;

    t_rsp rsp_queue [$];
    int   error_count;
    int   cycle_count;

    typedef struct {
        t_req req;
        logic has_rsp;
        t_rsp rsp;
    } t_row;

    function automatic t_rsp predict_list_op(t_req r);
        t_rsp               o;
        int                 slot;
        int                 i;
        int                 j;
        logic signed [31:0] tmp;
        longint             sum;
        longint             lo;
        longint             hi;
        o = '0;
        o.status = ST_OK;
        case (r.mode)
            MODE_APPEND, MODE_SORTED, MODE_INSERT: begin
                if (shadow_len >= CAP) begin
                    o.status = ST_FULL;
                end else begin
                    slot = -1;
                    if (r.mode == MODE_APPEND) begin
                        slot = shadow_len;
                    end else if (r.mode == MODE_SORTED) begin
                        slot = shadow_len;
                        if (shadow_len == 0 || shadow_list[0] > r.value) begin
                            slot = 0;
                        end else begin
                            for (i = 0; i < shadow_len; i++) begin
                                if (shadow_list[i] <= r.value && (i + 1 == shadow_len ||
                                        shadow_list[i+1] > r.value)) begin
                                    slot = i + 1;
                                    break;
                                end
                            end
                        end
                    end else if (r.position < 1 || r.position > shadow_len + 1) begin
                        o.status = ST_BADPOS;
                    end else begin
                        slot = r.position - 1;
                    end
                    if (slot >= 0) begin
                        for (i = shadow_len; i > slot; i--) shadow_list[i] = shadow_list[i-1];
                        shadow_list[slot] = r.value;
                        shadow_len++;
                    end
                end
            end
            MODE_DELETE: begin
                if (shadow_len == 0) begin
                    o.status = ST_EMPTY;
                end else if (r.position < 1 || r.position > shadow_len) begin
                    o.status = ST_BADPOS;
                end else begin
                    for (i = r.position - 1; i + 1 < shadow_len; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_len--;
                end
            end
            MODE_SORT: begin
                for (i = 0; i + 1 < shadow_len; i++) begin
                    for (j = i + 1; j < shadow_len; j++) begin
                        if (shadow_list[j] < shadow_list[i]) begin
                            tmp = shadow_list[i];
                            shadow_list[i] = shadow_list[j];
                            shadow_list[j] = tmp;
                        end
                    end
                end
            end
            MODE_READ: begin
                if (shadow_len == 0) begin
                    o.status = ST_EMPTY;
                end else if (r.position < 1 || r.position > shadow_len) begin
                    o.status = ST_BADPOS;
                end else begin
                    o.read_value = shadow_list[r.position - 1];
                end
            end
            MODE_STATS: begin
                if (shadow_len == 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    lo  = shadow_list[0];
                    hi  = lo;
                    sum = 0;
                    for (i = 0; i < shadow_len; i++) begin
                        if (shadow_list[i] < lo) lo = shadow_list[i];
                        if (shadow_list[i] > hi) hi = shadow_list[i];
                        sum += shadow_list[i];
                    end
                    o.minimum = lo[31:0];
                    o.maximum = hi[31:0];
                    o.total   = sum[35:0];
                    // SV division truncates toward zero
                    o.average = 32'(sum / longint'(shadow_len));
                end
            end
            default: ;
        endcase
        o.entry_count = 5'(shadow_len);
        return o;
    endfunction

    function automatic t_req mk(logic [2:0] m, logic signed [31:0] v, logic [4:0] p);
        t_req r;
        r.mode = m;
        r.value = v;
        r.position = p;
        return r;
    endfunction

    // called at a falling edge
    task automatic drop_req();
        i_req_valid <= 1'b0;
        i_req       <= mk(MODE_APPEND, $urandom, 5'($urandom));
    endtask

    // called at a falling edge; returns at the falling edge after the accept
    task automatic send_req(t_req r);
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            drop_req();
            repeat (gap) @(negedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        @(posedge i_clk);
        while (o_req_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic run_req(t_req r, logic has_rsp, t_rsp want);
        t_rsp pred;
        pred = predict_list_op(r);
        if (has_rsp && pred !== want) begin
            $error("directed table row disagrees with predictor for mode %0d", r.mode);
            error_count++;
        end
        rsp_queue.push_back(pred);
        send_req(r);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) begin
            if (rsp_queue.size() == 0) begin
                $error("unexpected result transaction");
                error_count++;
            end else begin
                exp_rsp = rsp_queue.pop_front();
                if (o_rsp.status !== exp_rsp.status) begin
                    $error("status exp %0d got %0d", exp_rsp.status, o_rsp.status);
                    error_count++;
                end
                if (o_rsp.entry_count !== exp_rsp.entry_count) begin
                    $error("entry_count exp %0d got %0d", exp_rsp.entry_count,
                           o_rsp.entry_count);
                    error_count++;
                end
                if (o_rsp.read_value !== exp_rsp.read_value) begin
                    $error("read_value exp %0d got %0d", exp_rsp.read_value,
                           o_rsp.read_value);
                    error_count++;
                end
                if (o_rsp.minimum !== exp_rsp.minimum) begin
                    $error("minimum exp %0d got %0d", exp_rsp.minimum, o_rsp.minimum);
                    error_count++;
                end
                if (o_rsp.maximum !== exp_rsp.maximum) begin
                    $error("maximum exp %0d got %0d", exp_rsp.maximum, o_rsp.maximum);
                    error_count++;
                end
                if (o_rsp.total !== exp_rsp.total) begin
                    $error("total exp %0d got %0d", exp_rsp.total, o_rsp.total);
                    error_count++;
                end
                if (o_rsp.average !== exp_rsp.average) begin
                    $error("average exp %0d got %0d", exp_rsp.average, o_rsp.average);
                    error_count++;
                end
            end
        end
    end

    // receiver stall: draw a wait per result
    initial begin
        int wait_cyc;
        i_rsp_stall = 1'b1;
        forever begin
            @(negedge i_clk);
            wait_cyc = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (wait_cyc > 0) begin
                i_rsp_stall <= 1'b1;
                repeat (wait_cyc) @(negedge i_clk);
            end
            i_rsp_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_rsp_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYC_LIMIT) begin
            $display("tb_ordered_list_engine: done, errors");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 5))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'($signed($urandom_range(0, 20)) - 10);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_req rand_req();
        t_req       r;
        int         pick;
        logic [2:0] m;
        pick = $urandom_range(0, 99);
        // fixed mode weights out of 100, the same at every fill level; 3'd7 is an unknown mode
        if (pick < 12)      m = MODE_APPEND;
        else if (pick < 24) m = MODE_SORTED;
        else if (pick < 36) m = MODE_INSERT;
        else if (pick < 56) m = MODE_DELETE;
        else if (pick < 64) m = MODE_SORT;
        else if (pick < 84) m = MODE_READ;
        else if (pick < 98) m = MODE_STATS;
        else                m = 3'd7;
        r.mode  = m;
        r.value = rand_value();
        if ($urandom_range(0, 9) == 0) r.position = 5'($urandom);
        else                           r.position = 5'($urandom_range(1, shadow_len + 1));
        return r;
    endfunction

    t_row stim_table [$];

    task automatic add_row(t_req r, logic has_rsp, logic [1:0] st, int cnt);
        t_row row;
        row.req = r;
        row.has_rsp = has_rsp;
        row.rsp = '0;
        row.rsp.status = st;
        row.rsp.entry_count = 5'(cnt);
        stim_table.push_back(row);
    endtask

    initial begin
        int k;
        error_count = 0;
        cycle_count = 0;
        shadow_len  = 0;
        i_rst_n     = 1'b0;
        i_req_valid = 1'b0;
        i_req       = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty list cases, bad positions, filling to capacity and rejects when full
        add_row(mk(MODE_STATS,  0, 5'd1), 1'b1, ST_EMPTY, 0);
        add_row(mk(MODE_READ,   0, 5'd1), 1'b1, ST_EMPTY, 0);
        add_row(mk(MODE_DELETE, 0, 5'd1), 1'b1, ST_EMPTY, 0);
        add_row(mk(MODE_SORT,   0, 5'd0), 1'b1, ST_OK, 0);
        add_row(mk(3'd7,        0, 5'd0), 1'b1, ST_OK, 0);
        add_row(mk(MODE_INSERT, 5, 5'd2), 1'b1, ST_BADPOS, 0);
        add_row(mk(MODE_INSERT, 5, 5'd0), 1'b1, ST_BADPOS, 0);
        add_row(mk(MODE_INSERT, 32'sh7FFF_FFFF, 5'd1), 1'b1, ST_OK, 1);
        add_row(mk(MODE_APPEND, 32'sh8000_0000, 5'd0), 1'b1, ST_OK, 2);
        add_row(mk(MODE_SORTED, 0, 5'd0), 1'b0, ST_OK, 0);
        add_row(mk(MODE_READ,   0, 5'd31), 1'b1, ST_BADPOS, 3);
        add_row(mk(MODE_READ,   0, 5'd0), 1'b1, ST_BADPOS, 3);
        add_row(mk(MODE_STATS,  0, 5'd0), 1'b0, ST_OK, 0);
        add_row(mk(MODE_SORT,   0, 5'd0), 1'b0, ST_OK, 0);
        add_row(mk(MODE_READ,   0, 5'd1), 1'b0, ST_OK, 0);
        add_row(mk(MODE_DELETE, 0, 5'd4), 1'b1, ST_BADPOS, 3);
        add_row(mk(MODE_DELETE, 0, 5'd2), 1'b1, ST_OK, 2);
        for (k = 0; k < 14; k++) add_row(mk(MODE_SORTED, 32'sh7FFF_FFFF, 5'd0), 1'b0, ST_OK, 0);
        add_row(mk(MODE_APPEND, 1, 5'd0), 1'b1, ST_FULL, 16);
        add_row(mk(MODE_INSERT, 1, 5'd17), 1'b1, ST_FULL, 16);
        add_row(mk(MODE_STATS,  0, 5'd0), 1'b0, ST_OK, 0);
        add_row(mk(MODE_READ,   0, 5'd16), 1'b0, ST_OK, 0);
        add_row(mk(MODE_DELETE, 0, 5'd16), 1'b1, ST_OK, 15);

        foreach (stim_table[n]) run_req(stim_table[n].req, stim_table[n].has_rsp,
                                        stim_table[n].rsp);

        for (k = 0; k < N_RANDOM; k++) begin
            if (k == N_RANDOM / 2) begin
                // drain fully before continuing
                drop_req();
                while (rsp_queue.size() != 0) @(posedge i_clk);
                @(negedge i_clk);
            end
            run_req(rand_req(), 1'b0, '0);
        end

        drop_req();
        while (rsp_queue.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_ordered_list_engine: done, clean");
        end else begin
            $display("tb_ordered_list_engine: done, errors");
        end
        $finish;
    end

endmodule

// ===== ordered_list_engine.f =====
hw/rtl/ole_pkg.sv
hw/rtl/ordered_list_engine.sv
bench/tb_ordered_list_engine.sv
